/* hw/rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and helper functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MaxRes = 4;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;

  typedef enum logic [2:0] {
    MODE_OUTSIDE = 3'd0,
    MODE_BODY    = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX1    = 3'd3,
    MODE_HIGH    = 3'd4,
    MODE_HIGH_BS = 3'd5,
    MODE_HEX2    = 3'd6
  } mode_t;

  // One input byte's worth of results, slot 0 goes out first.
  typedef struct packed {
    logic [2:0]            count;
    logic [MaxRes-1:0][7:0] data;
    logic [MaxRes-1:0]      fin;
  } group_t;

  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] data;
  } utf8_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - 8'h30;
    end else if (b inside {[8'h61:8'h66]}) begin
      d = b - 8'h57;
    end else if (b inside {[8'h41:8'h46]}) begin
      d = b - 8'h37;
    end
    return d[3:0];
  endfunction

  // Single-byte escape map; unknown escapes pass through.
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] o;
    case (b)
      8'h6E:   o = 8'h0A;
      8'h74:   o = 8'h09;
      8'h72:   o = 8'h0D;
      8'h62:   o = 8'h08;
      8'h66:   o = 8'h0C;
      default: o = b;
    endcase
    return o;
  endfunction

  function automatic utf8_t utf8_unit(input logic [15:0] u);
    utf8_t r;
    r = '0;
    if (u < 16'h0080) begin
      r.count   = 2'd1;
      r.data[0] = u[7:0];
    end else if (u < 16'h0800) begin
      r.count   = 2'd2;
      r.data[0] = 8'hC0 | {3'b000, u[10:6]};
      r.data[1] = 8'h80 | {2'b00, u[5:0]};
    end else begin
      r.count   = 2'd3;
      r.data[0] = 8'hE0 | {4'h0, u[15:12]};
      r.data[1] = 8'h80 | {2'b00, u[11:6]};
      r.data[2] = 8'h80 | {2'b00, u[5:0]};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/jsu_decode.sv */
// ----------------------------------------------------------------------------
// jsu_decode
// Decoder state and per-byte decode into a group of up to four result bytes.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      byte_in,
  output jsu_pkg::group_t group
);

  jsu_pkg::mode_t mode, mode_next;
  logic [15:0] code_unit, code_unit_next;
  logic [15:0] high_unit, high_unit_next;
  logic [1:0]  digit_count, digit_count_next;

  logic [15:0]         unit_shift;
  logic                digit_done;
  logic [20:0]         cp;
  jsu_pkg::utf8_t      hi_enc, unit_enc;
  logic                is_quote, is_bs, is_u;
  jsu_pkg::mode_t      body_mode;
  logic [7:0]          body_data;
  logic [7:0]          esc_data;

  always_comb begin
    unit_shift = {code_unit[11:0], jsu_pkg::hex_digit(byte_in)};
    digit_done = (digit_count == 2'd3);
    // 0x10000 + (hi-0xD800)<<10 + (lo-0xDC00); high unit is always a surrogate
    cp = {1'b0, high_unit[9:0], 10'b0} + {5'b0, unit_shift} + 21'h002400;
    hi_enc   = jsu_pkg::utf8_unit(high_unit);
    unit_enc = jsu_pkg::utf8_unit(unit_shift);
    is_quote = (byte_in == jsu_pkg::ChQuote);
    is_bs    = (byte_in == jsu_pkg::ChBslash);
    is_u     = (byte_in == jsu_pkg::ChU);
    body_mode = is_quote ? jsu_pkg::MODE_OUTSIDE :
                is_bs    ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_BODY;
    body_data = is_quote ? 8'h00 : byte_in;
    esc_data  = jsu_pkg::esc_map(byte_in);
  end

  always_comb begin
    group            = '0;
    mode_next        = mode;
    code_unit_next   = code_unit;
    high_unit_next   = high_unit;
    digit_count_next = digit_count;
    case (mode)
      jsu_pkg::MODE_BODY: begin
        mode_next = body_mode;
        if (!is_bs) begin
          group.count   = 3'd1;
          group.data[0] = body_data;
          group.fin[0]  = is_quote;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (is_u) begin
          code_unit_next   = '0;
          digit_count_next = '0;
          mode_next        = jsu_pkg::MODE_HEX1;
        end else begin
          mode_next     = jsu_pkg::MODE_BODY;
          group.count   = 3'd1;
          group.data[0] = esc_data;
        end
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        code_unit_next   = unit_shift;
        digit_count_next = digit_done ? 2'd0 : digit_count + 2'd1;
        if (digit_done) begin
          if (mode == jsu_pkg::MODE_HEX2) begin
            mode_next     = jsu_pkg::MODE_BODY;
            group.count   = 3'd4;
            group.data[0] = 8'hF0 | {5'b0, cp[20:18]};
            group.data[1] = 8'h80 | {2'b0, cp[17:12]};
            group.data[2] = 8'h80 | {2'b0, cp[11:6]};
            group.data[3] = 8'h80 | {2'b0, cp[5:0]};
          end else if (unit_shift inside {[16'hD800:16'hDBFF]}) begin
            high_unit_next = unit_shift;
            mode_next      = jsu_pkg::MODE_HIGH;
          end else begin
            mode_next     = jsu_pkg::MODE_BODY;
            group.count   = {1'b0, unit_enc.count};
            group.data[0] = unit_enc.data[0];
            group.data[1] = unit_enc.data[1];
            group.data[2] = unit_enc.data[2];
          end
        end
      end
      jsu_pkg::MODE_HIGH: begin
        if (is_bs) begin
          mode_next = jsu_pkg::MODE_HIGH_BS;
        end else begin
          // lone high surrogate (3 bytes), then the byte as body text
          mode_next     = body_mode;
          group.count   = 3'd4;
          group.data[0] = hi_enc.data[0];
          group.data[1] = hi_enc.data[1];
          group.data[2] = hi_enc.data[2];
          group.data[3] = body_data;
          group.fin[3]  = is_quote;
        end
      end
      jsu_pkg::MODE_HIGH_BS: begin
        code_unit_next   = '0;
        digit_count_next = '0;
        if (is_u) begin
          mode_next = jsu_pkg::MODE_HEX2;
        end else begin
          code_unit_next   = code_unit;
          digit_count_next = digit_count;
          mode_next        = jsu_pkg::MODE_BODY;
          group.count      = 3'd4;
          group.data[0]    = hi_enc.data[0];
          group.data[1]    = hi_enc.data[1];
          group.data[2]    = hi_enc.data[2];
          group.data[3]    = esc_data;
        end
      end
      default: begin
        mode_next = is_quote ? jsu_pkg::MODE_BODY : jsu_pkg::MODE_OUTSIDE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= jsu_pkg::MODE_OUTSIDE;
      code_unit   <= '0;
      high_unit   <= '0;
      digit_count <= '0;
    end else if (fire) begin
      mode        <= mode_next;
      code_unit   <= code_unit_next;
      high_unit   <= high_unit_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

/* hw/rtl/jsu_outq.sv */
// ----------------------------------------------------------------------------
// jsu_outq
// Result register: holds one decoded group and sends its bytes one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module jsu_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jsu_pkg::group_t group,
  output logic            free,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      data_byte,
  output logic            string_end,
  output logic            last
);

  jsu_pkg::group_t grp;
  logic [1:0]      idx;
  logic            full;

  always_comb begin
    last       = ({1'b0, idx} + 3'd1) == grp.count;
    out_valid  = full;
    data_byte  = grp.data[idx];
    string_end = grp.fin[idx];
    free       = !full || (out_ready && last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (full && out_ready) begin
      if (last) begin
        full <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= group;
    end
  end

endmodule

/* hw/rtl/json_string_unescape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper producing UTF-8 bytes with an end marker.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready carry one byte of JSON text per item.
// Bytes outside a string are dropped until an opening quote; the body is
// decoded (escapes, \u code units, surrogate pairs) into UTF-8 bytes.
// Output channel: out_valid/out_ready carry one result item per handshake:
// data_byte, string_end (closing quote, data_byte zero) and last, which
// marks the final result caused by one input byte.
// An accepted byte is held in the input register, is decoded into the
// result register, and its first result is offered from there.
// Throughput: one byte per cycle while each byte makes at most one result
// and the receiver does not stall; a byte that makes more than one result
// holds the result register until its last result is taken, and bytes
// that make no result pass through the input register every cycle.
// Reset (rst, synchronous) returns to the outside-string state and empties
// both registers. When the receiver stalls, the result register holds and
// the input register fills, after which in_ready drops.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       string_end,
  output logic       last
);

  logic            in_full;
  logic [7:0]      byte_r;
  logic            fire;
  logic            q_free;
  jsu_pkg::group_t group;

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (byte_r),
    .group   (group)
  );

  jsu_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (fire && (group.count != 3'd0)),
    .group      (group),
    .free       (q_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .string_end (string_end),
    .last       (last)
  );

  // bytes with no result never wait on the result register
  assign fire     = in_full && ((group.count == 3'd0) || q_free);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

/* hw/rtl/jsu_checker.sv */
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic       string_end,
  input logic       last
);

  // results sent since the last item marked last
  logic [2:0] run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else if (out_valid && out_ready) begin
      run <= last ? 3'd0 : run + 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) &&
      $stable(string_end) && $stable(last))
    else $error("result changed while stalled");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> data_byte == 8'h00)
    else $error("end marker with nonzero data");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> last)
    else $error("end marker not last result of its byte");

  a_max_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run < 3'd4)
    else $error("more than four results for one byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle right after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .data_byte  (data_byte),
  .string_end (string_end),
  .last       (last)
);

/* tb/sv/json_string_unescape_utf8_tb.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb
// Self-checking bench for the JSON string unescaper: a short table of
// hand-picked text (edge bytes, surrogate handling, quotes inside hex digits)
// followed by random JSON strings, all but typed rows scored against an in-bench decoder.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDir       = 31;
  localparam int RandBytes  = 440;
  localparam int QuietLo    = 200;
  localparam int QuietHi    = 300;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 8;

  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChSlash = 8'h2F;

  typedef struct packed {
    logic [7:0] data;
    logic       str_end;
    logic       last;
  } result_t;

  // typed rows carry their own expectation: none, or one result with last set
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic       has_res;
    logic [7:0] d;
    logic       e;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic       string_end;
  logic       last;

  json_string_unescape_utf8 uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .string_end (string_end),
    .last       (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // opening text, a surrogate pair with a quote and a non-hex byte among the
  // low digits, a high unit cut off by an escaped quote, a high unit cut off
  // by the closing quote
  row_t dir_tab [NDir] = '{
    '{"x",               1'b1, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChQuote,  1'b1, 1'b0, 8'h00, 1'b0},
    '{8'h00,             1'b1, 1'b1, 8'h00, 1'b0},
    '{8'hFF,             1'b1, 1'b1, 8'hFF, 1'b0},
    '{jsu_pkg::ChBslash, 1'b1, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChU,      1'b1, 1'b0, 8'h00, 1'b0},
    '{"D",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"B",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"F",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"F",               1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChBslash, 1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChU,      1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChQuote,  1'b0, 1'b0, 8'h00, 1'b0},
    '{"g",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"0",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"0",               1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChBslash, 1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChU,      1'b0, 1'b0, 8'h00, 1'b0},
    '{"d",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"8",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"0",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"0",               1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChBslash, 1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChQuote,  1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChBslash, 1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChU,      1'b0, 1'b0, 8'h00, 1'b0},
    '{"D",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"8",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"0",               1'b0, 1'b0, 8'h00, 1'b0},
    '{"0",               1'b0, 1'b0, 8'h00, 1'b0},
    '{jsu_pkg::ChQuote,  1'b0, 1'b0, 8'h00, 1'b0}
  };

  logic [7:0] text_q [$];
  result_t    expected_bytes_q [$];
  result_t    step_bytes [$];

  // decoder state
  jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_OUTSIDE;
  logic [15:0]    dec_unit = '0;
  logic [15:0]    dec_high = '0;
  logic [1:0]     dec_ndig = '0;

  bit quiet = 1'b0;
  int errors = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int strings_closed = 0;
  int stall_cycles = 0;

  // ---------------------------------------------------------------- decoder
  function automatic void emit(input logic [7:0] d, input logic e);
    step_bytes.push_back('{data: d, str_end: e, last: 1'b0});
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return 4'(b - "0");
    if (b >= "a" && b <= "f") return 4'(b - "a" + 10);
    if (b >= "A" && b <= "F") return 4'(b - "A" + 10);
    return 4'h0;
  endfunction

  function automatic bit take_digit(input logic [7:0] b);
    dec_unit = {dec_unit[11:0], nibble_of(b)};
    if (dec_ndig == 2'd3) begin
      dec_ndig = 2'd0;
      return 1'b1;
    end
    dec_ndig = dec_ndig + 2'd1;
    return 1'b0;
  endfunction

  function automatic void emit_unit(input logic [15:0] u);
    if (u < 16'h0080) begin
      emit(u[7:0], 1'b0);
    end else if (u < 16'h0800) begin
      emit({3'b110, u[10:6]}, 1'b0);
      emit({2'b10, u[5:0]}, 1'b0);
    end else begin
      emit({4'b1110, u[15:12]}, 1'b0);
      emit({2'b10, u[11:6]}, 1'b0);
      emit({2'b10, u[5:0]}, 1'b0);
    end
  endfunction

  function automatic void body_char(input logic [7:0] b);
    if (b == jsu_pkg::ChQuote) begin
      emit(8'h00, 1'b1);
      dec_mode = jsu_pkg::MODE_OUTSIDE;
    end else if (b == jsu_pkg::ChBslash) begin
      dec_mode = jsu_pkg::MODE_ESC;
    end else begin
      emit(b, 1'b0);
      dec_mode = jsu_pkg::MODE_BODY;
    end
  endfunction

  function automatic void escape_char(input logic [7:0] b);
    dec_mode = jsu_pkg::MODE_BODY;
    case (b)
      ChN: emit(8'h0A, 1'b0);
      ChT: emit(8'h09, 1'b0);
      ChR: emit(8'h0D, 1'b0);
      ChB: emit(8'h08, 1'b0);
      ChF: emit(8'h0C, 1'b0);
      jsu_pkg::ChU: begin
        dec_unit = '0;
        dec_ndig = '0;
        dec_mode = jsu_pkg::MODE_HEX1;
      end
      default: emit(b, 1'b0);
    endcase
  endfunction

  // decodes one byte into step_bytes, last flag set on the final one
  function automatic void unescape_byte(input logic [7:0] b);
    logic [31:0] cp;
    step_bytes.delete();
    case (dec_mode)
      jsu_pkg::MODE_BODY: body_char(b);
      jsu_pkg::MODE_ESC:  escape_char(b);
      jsu_pkg::MODE_HEX1: begin
        if (take_digit(b)) begin
          if (dec_unit >= 16'hD800 && dec_unit <= 16'hDBFF) begin
            dec_high = dec_unit;
            dec_mode = jsu_pkg::MODE_HIGH;
          end else begin
            emit_unit(dec_unit);
            dec_mode = jsu_pkg::MODE_BODY;
          end
        end
      end
      jsu_pkg::MODE_HIGH: begin
        if (b == jsu_pkg::ChBslash) begin
          dec_mode = jsu_pkg::MODE_HIGH_BS;
        end else begin
          emit_unit(dec_high);
          body_char(b);
        end
      end
      jsu_pkg::MODE_HIGH_BS: begin
        if (b == jsu_pkg::ChU) begin
          dec_unit = '0;
          dec_ndig = '0;
          dec_mode = jsu_pkg::MODE_HEX2;
        end else begin
          emit_unit(dec_high);
          escape_char(b);
        end
      end
      jsu_pkg::MODE_HEX2: begin
        if (take_digit(b)) begin
          // low unit is not range checked, wraps modulo 2^32
          cp = 32'h10000 + ((32'(dec_high) - 32'hD800) << 10)
               + (32'(dec_unit) - 32'hDC00);
          emit(8'hF0 | cp[25:18], 1'b0);
          emit({2'b10, cp[17:12]}, 1'b0);
          emit({2'b10, cp[11:6]}, 1'b0);
          emit({2'b10, cp[5:0]}, 1'b0);
          dec_mode = jsu_pkg::MODE_BODY;
        end
      end
      default: begin
        dec_mode = (b == jsu_pkg::ChQuote) ? jsu_pkg::MODE_BODY : jsu_pkg::MODE_OUTSIDE;
      end
    endcase
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------ random text
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == jsu_pkg::ChQuote || b == jsu_pkg::ChBslash) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic logic [15:0] pick_unit();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hFFFF));
      3: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // \u escape; a sloppy one may carry arbitrary bytes in place of digits
  function automatic void push_unit(input logic [15:0] u, input bit sloppy);
    text_q.push_back(jsu_pkg::ChBslash);
    text_q.push_back(jsu_pkg::ChU);
    for (int k = 3; k >= 0; k--) begin
      if (sloppy && $urandom_range(0, 2) == 0)
        text_q.push_back(($urandom_range(0, 3) == 0) ? jsu_pkg::ChQuote
                         : 8'($urandom_range(0, 255)));
      else
        text_q.push_back(hex_char(u[4*k +: 4]));
    end
  endfunction

  function automatic void push_escape();
    logic [7:0] c;
    case ($urandom_range(0, 8))
      0: c = ChN;
      1: c = ChT;
      2: c = ChR;
      3: c = ChB;
      4: c = ChF;
      5: c = ChSlash;
      6: c = jsu_pkg::ChQuote;
      7: c = jsu_pkg::ChBslash;
      default: c = 8'($urandom_range(0, 255));
    endcase
    text_q.push_back(jsu_pkg::ChBslash);
    text_q.push_back(c);
  endfunction

  function automatic void add_string();
    logic [7:0] b;
    int n_tok;
    n_tok = $urandom_range(0, 8);
    // broken text now and then
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 3))
          0: text_q.push_back(jsu_pkg::ChQuote);
          1: text_q.push_back(jsu_pkg::ChBslash);
          default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom_range(0, 255));
      text_q.push_back((b == jsu_pkg::ChQuote) ? 8'h00 : b);
    end
    text_q.push_back(jsu_pkg::ChQuote);
    repeat (n_tok) begin
      case ($urandom_range(0, 9))
        0, 1, 2: text_q.push_back(plain_char());
        3: push_escape();
        4, 5: push_unit(pick_unit(), 1'b0);
        6, 7: begin
          push_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
          push_unit(($urandom_range(0, 3) == 0) ? pick_unit()
                    : 16'($urandom_range(16'hDC00, 16'hDFFF)), 1'b0);
        end
        8: begin
          // high unit that is not followed by a pair
          push_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
          case ($urandom_range(0, 2))
            0: text_q.push_back(plain_char());
            1: push_escape();
            default: text_q.push_back(jsu_pkg::ChQuote);
          endcase
        end
        default: push_unit(pick_unit(), 1'b1);
      endcase
    end
    if ($urandom_range(0, 9) != 0) text_q.push_back(jsu_pkg::ChQuote);
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    got = '{data: data_byte, str_end: string_end, last: last};
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (got.str_end) strings_closed++;
      if (expected_bytes_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: data_byte=%02h string_end=%0b last=%0b",
                   got.data, got.str_end, got.last);
      end else begin
        want = expected_bytes_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("result %0d mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                     results_seen, want.data, want.str_end, want.last,
                     got.data, got.str_end, got.last);
        end
      end
    end
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  // no progress on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("timeout with %0d results outstanding", expected_bytes_q.size());
      $display("json_string_unescape_utf8 test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ----------------------------------------------------------------- driver
  initial begin
    logic [7:0] b;
    int total;
    while (text_q.size() < RandBytes) add_string();
    total = NDir + text_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < total; i++) begin
      quiet = (i >= QuietLo && i < QuietHi);
      b = (i < NDir) ? dir_tab[i].b : text_q[i - NDir];
      if (!quiet && $urandom_range(0, 99) < 25) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 2)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= b;
      do @(posedge clk); while (!in_ready);
      bytes_sent++;
      unescape_byte(b);
      if (i < NDir && dir_tab[i].typed) begin
        if (dir_tab[i].has_res)
          expected_bytes_q.push_back('{data: dir_tab[i].d, str_end: dir_tab[i].e, last: 1'b1});
      end else begin
        foreach (step_bytes[k]) expected_bytes_q.push_back(step_bytes[k]);
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (expected_bytes_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("sent %0d text bytes, checked %0d decoded results, %0d strings closed",
             bytes_sent, results_seen, strings_closed);
    if (errors == 0) begin
      $display("json_string_unescape_utf8 test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("json_string_unescape_utf8 test failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_outq.sv
hw/rtl/json_string_unescape_utf8.sv
hw/rtl/jsu_checker.sv
tb/sv/json_string_unescape_utf8_tb.sv
